@@ rtl/core/tzvs_pkg.sv @@
package tzvs_pkg;

    // Defaults for the top-level parameters.
    localparam int COORD_BITS_DEF = 12;
    localparam int ID_BITS_DEF    = 16;
    localparam int AXIS_FULL_DEF  = 32767;

    // Every axis leaves the block as a 16-bit two's complement value.
    localparam int AXIS_BITS = 16;

    // Entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    localparam int ZONE_BITS = 3;

    // What the front has decided a request is.
    typedef enum logic [ZONE_BITS-1:0] {
        ZONE_FIRE,
        ZONE_AIM,
        ZONE_USE,
        ZONE_START,
        ZONE_MOVE,
        ZONE_LOOK,
        ZONE_EOF
    } zone_t;

    // Configuration register indexes (byte address is four times the index).
    typedef enum logic [2:0] {
        REG_MOVE_ZONE_X     = 3'd0,
        REG_BUTTON_COLUMN_X = 3'd1,
        REG_FIRE_Y          = 3'd2,
        REG_AIM_TOP         = 3'd3,
        REG_USE_X_LOW       = 3'd4,
        REG_MOVE_DEADZONE   = 3'd5,
        REG_MOVE_SCALE      = 3'd6,
        REG_LOOK_GAIN       = 3'd7
    } reg_index_t;

endpackage

@@ rtl/core/touch_zone_virtual_stick_unit.sv @@
// Touch zone virtual stick.
// The input stream carries one request per touch sample (s_tuser low) and an end-of-frame
// request (s_tuser high) after the samples of each frame. Each sample is sorted into the
// fire, aim, use, start, move-stick or look zone; an end of frame produces one result on
// the output stream with the two stick axes, the two look axes and the four buttons.
// Samples produce no result.
// One request is taken every cycle while the queue is not full. A front stage classifies
// the sample and writes it into a four-entry queue; the back pops one entry a cycle while
// the result register can take a result, and runs it through three stages (ownership and
// displacement, the gain and deadzone multipliers, saturation and the frame axes). When
// the receiver holds m_tready low, the back halts with the result on hold, and the front
// keeps taking requests until the queue is full, at which point s_tready falls. Reset
// clears the queue, the stick and look owners, the frame flags and axes, and returns the
// configuration registers to their defaults. The APB port writes and reads the eight
// registers at byte addresses 0 to 28. It is to be written only while idle, by the user;
// the block itself does not enforce this.
module touch_zone_virtual_stick_unit #(
    parameter int COORD_BITS = tzvs_pkg::COORD_BITS_DEF,
    parameter int ID_BITS    = tzvs_pkg::ID_BITS_DEF,
    parameter int AXIS_FULL  = tzvs_pkg::AXIS_FULL_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata, from bit 0 up: touch_x, touch_y, finger_id, zero fill.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [((2*COORD_BITS+ID_BITS+7)/8)*8-1:0] s_tdata,
    // s_tuser: command (0 finger sample, 1 end of frame).
    input  logic                 s_tuser,
    // m_tdata, from bit 0 up: left_x, left_y, right_x, right_y, fire, aim, use_res,
    // start_res, zero fill.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [((4*tzvs_pkg::AXIS_BITS+4+7)/8)*8-1:0] m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import tzvs_pkg::*;

    localparam int S_TDATA_W = ((2 * COORD_BITS + ID_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((4 * AXIS_BITS + 4 + 7) / 8) * 8;
    localparam int Q_W       = ZONE_BITS + ID_BITS + 2 * COORD_BITS;

    logic [COORD_BITS-1:0] move_zone_x_reg;
    logic [COORD_BITS-1:0] button_column_x_reg;
    logic [COORD_BITS-1:0] fire_y_reg;
    logic [COORD_BITS-1:0] aim_top_reg;
    logic [COORD_BITS-1:0] use_x_low_reg;
    logic [COORD_BITS-1:0] move_deadzone_reg;
    logic [15:0]           move_scale_reg;
    logic [15:0]           look_gain_reg;

    reg_index_t            reg_index;
    logic                  cfg_write;

    logic                  q_push, q_full, q_pop, q_valid;
    zone_t                 f_zone;
    logic [COORD_BITS-1:0] f_x, f_y;
    logic [ID_BITS-1:0]    f_id;
    logic [Q_W-1:0]        q_wdata, q_rdata;
    zone_t                 b_zone;

    assign reg_index = reg_index_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_zone_x_reg     <= COORD_BITS'(1638);
            button_column_x_reg <= COORD_BITS'(3523);
            fire_y_reg          <= COORD_BITS'(2540);
            aim_top_reg         <= COORD_BITS'(1147);
            use_x_low_reg       <= COORD_BITS'(2908);
            move_deadzone_reg   <= COORD_BITS'(49);
            move_scale_reg      <= 16'd18619;
            look_gain_reg       <= 16'd28672;
        end else if (cfg_write) begin
            case (reg_index)
                REG_MOVE_ZONE_X:     move_zone_x_reg     <= pwdata[COORD_BITS-1:0];
                REG_BUTTON_COLUMN_X: button_column_x_reg <= pwdata[COORD_BITS-1:0];
                REG_FIRE_Y:          fire_y_reg          <= pwdata[COORD_BITS-1:0];
                REG_AIM_TOP:         aim_top_reg         <= pwdata[COORD_BITS-1:0];
                REG_USE_X_LOW:       use_x_low_reg       <= pwdata[COORD_BITS-1:0];
                REG_MOVE_DEADZONE:   move_deadzone_reg   <= pwdata[COORD_BITS-1:0];
                REG_MOVE_SCALE:      move_scale_reg      <= pwdata[15:0];
                REG_LOOK_GAIN:       look_gain_reg       <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_MOVE_ZONE_X:     prdata = 32'(move_zone_x_reg);
            REG_BUTTON_COLUMN_X: prdata = 32'(button_column_x_reg);
            REG_FIRE_Y:          prdata = 32'(fire_y_reg);
            REG_AIM_TOP:         prdata = 32'(aim_top_reg);
            REG_USE_X_LOW:       prdata = 32'(use_x_low_reg);
            REG_MOVE_DEADZONE:   prdata = 32'(move_deadzone_reg);
            REG_MOVE_SCALE:      prdata = 32'(move_scale_reg);
            REG_LOOK_GAIN:       prdata = 32'(look_gain_reg);
            default:             prdata = '0;
        endcase
    end

    tzvs_front #(
        .COORD_BITS (COORD_BITS),
        .ID_BITS    (ID_BITS),
        .TDATA_W    (S_TDATA_W)
    ) u_front (
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .move_zone_x     (move_zone_x_reg),
        .button_column_x (button_column_x_reg),
        .fire_y          (fire_y_reg),
        .aim_top         (aim_top_reg),
        .use_x_low       (use_x_low_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_zone          (f_zone),
        .q_x             (f_x),
        .q_y             (f_y),
        .q_id            (f_id)
    );

    assign q_wdata = {f_zone, f_id, f_y, f_x};

    tzvs_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rvalid  (q_valid),
        .rdata   (q_rdata)
    );

    assign b_zone = zone_t'(q_rdata[Q_W-1:Q_W-ZONE_BITS]);

    tzvs_back #(
        .COORD_BITS (COORD_BITS),
        .ID_BITS    (ID_BITS),
        .AXIS_FULL  (AXIS_FULL),
        .M_TDATA_W  (M_TDATA_W)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_zone        (b_zone),
        .q_x           (q_rdata[COORD_BITS-1:0]),
        .q_y           (q_rdata[2*COORD_BITS-1:COORD_BITS]),
        .q_id          (q_rdata[2*COORD_BITS+ID_BITS-1:2*COORD_BITS]),
        .move_deadzone (move_deadzone_reg),
        .move_scale    (move_scale_reg),
        .look_gain     (look_gain_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule

@@ rtl/core/tzvs_fifo.sv @@
module tzvs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             rvalid,
    output logic [WIDTH-1:0] rdata
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign rvalid = (count_reg != '0);
    assign rdata  = mem_reg[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop) begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

@@ rtl/core/tzvs_front.sv @@
module tzvs_front #(
    parameter int COORD_BITS = tzvs_pkg::COORD_BITS_DEF,
    parameter int ID_BITS    = tzvs_pkg::ID_BITS_DEF,
    parameter int TDATA_W    = 40
) (
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,
    input  logic                  s_tuser,
    input  logic [COORD_BITS-1:0] move_zone_x,
    input  logic [COORD_BITS-1:0] button_column_x,
    input  logic [COORD_BITS-1:0] fire_y,
    input  logic [COORD_BITS-1:0] aim_top,
    input  logic [COORD_BITS-1:0] use_x_low,
    input  logic                  q_full,
    output logic                  q_push,
    output tzvs_pkg::zone_t       q_zone,
    output logic [COORD_BITS-1:0] q_x,
    output logic [COORD_BITS-1:0] q_y,
    output logic [ID_BITS-1:0]    q_id
);
    import tzvs_pkg::*;

    // Fixed bounds as fractions of full scale, rounded to the nearest step.
    localparam int USE_Y_I      = ((74 << COORD_BITS) + 50) / 100;
    localparam int START_X_LO_I = ((45 << COORD_BITS) + 50) / 100;
    localparam int START_X_HI_I = ((55 << COORD_BITS) + 50) / 100;
    localparam int START_Y_I    = ((9 << COORD_BITS) + 50) / 100;
    localparam logic [COORD_BITS-1:0] USE_Y      = COORD_BITS'(USE_Y_I);
    localparam logic [COORD_BITS-1:0] START_X_LO = COORD_BITS'(START_X_LO_I);
    localparam logic [COORD_BITS-1:0] START_X_HI = COORD_BITS'(START_X_HI_I);
    localparam logic [COORD_BITS-1:0] START_Y    = COORD_BITS'(START_Y_I);

    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  col;

    assign x    = s_tdata[COORD_BITS-1:0];
    assign y    = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign q_id = s_tdata[2*COORD_BITS+ID_BITS-1:2*COORD_BITS];
    assign q_x  = x;
    assign q_y  = y;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    assign col = (x >= button_column_x);

    // The zones are tested in priority order; the first that holds the point wins.
    always_comb begin
        if (s_tuser) begin
            q_zone = ZONE_EOF;
        end else if (col && y >= fire_y) begin
            q_zone = ZONE_FIRE;
        end else if (col && y >= aim_top && y < fire_y) begin
            q_zone = ZONE_AIM;
        end else if (x >= use_x_low && x < button_column_x && y >= USE_Y) begin
            q_zone = ZONE_USE;
        end else if (x >= START_X_LO && x <= START_X_HI && y <= START_Y) begin
            q_zone = ZONE_START;
        end else if (x < move_zone_x) begin
            q_zone = ZONE_MOVE;
        end else begin
            q_zone = ZONE_LOOK;
        end
    end

endmodule

@@ rtl/core/tzvs_back.sv @@
module tzvs_back #(
    parameter int COORD_BITS = tzvs_pkg::COORD_BITS_DEF,
    parameter int ID_BITS    = tzvs_pkg::ID_BITS_DEF,
    parameter int AXIS_FULL  = tzvs_pkg::AXIS_FULL_DEF,
    parameter int M_TDATA_W  = 72
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  tzvs_pkg::zone_t       q_zone,
    input  logic [COORD_BITS-1:0] q_x,
    input  logic [COORD_BITS-1:0] q_y,
    input  logic [ID_BITS-1:0]    q_id,
    input  logic [COORD_BITS-1:0] move_deadzone,
    input  logic [15:0]           move_scale,
    input  logic [15:0]           look_gain,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata
);
    import tzvs_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = COORD_BITS + 16;
    localparam int VW = COORD_BITS + 8;
    localparam int SW = 2 * COORD_BITS;

    localparam int FL_FIRE  = 0;
    localparam int FL_AIM   = 1;
    localparam int FL_USE   = 2;
    localparam int FL_START = 3;
    localparam int FL_MOVE  = 4;
    localparam int FL_LOOK  = 5;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_MOVE,
        KIND_LOOK,
        KIND_EOF
    } kind_t;

    function automatic logic [AXIS_BITS-1:0] sat_axis(input logic [PW-1:0] prod,
                                                      input logic neg);
        logic [VW-1:0]        v;
        logic [AXIS_BITS-1:0] m;
        v = prod[PW-1:8];
        if (v > VW'(AXIS_FULL)) begin
            m = AXIS_BITS'(AXIS_FULL);
        end else begin
            m = v[AXIS_BITS-1:0];
        end
        return neg ? (~m + 1'b1) : m;
    endfunction

    logic en;

    // Ownership state and frame flags.
    logic                  stick_owned_reg, stick_owned_next;
    logic [ID_BITS-1:0]    stick_owner_reg, stick_owner_next;
    logic [COORD_BITS-1:0] stick_ox_reg, stick_ox_next;
    logic [COORD_BITS-1:0] stick_oy_reg, stick_oy_next;
    logic                  look_owned_reg, look_owned_next;
    logic [ID_BITS-1:0]    look_owner_reg, look_owner_next;
    logic [COORD_BITS-1:0] look_lx_reg, look_lx_next;
    logic [COORD_BITS-1:0] look_ly_reg, look_ly_next;
    logic [5:0]            flags_reg, flags_next;

    // Stage A: displacement.
    kind_t                 a_kind_reg, a_kind_next;
    logic signed [DW-1:0]  a_dx_reg, a_dx_next;
    logic signed [DW-1:0]  a_dy_reg, a_dy_next;
    logic [5:0]            a_flags_reg, a_flags_next;

    // Stage B: products.
    kind_t                 b_kind_reg;
    logic                  b_neg_x_reg, b_neg_y_reg;
    logic [PW-1:0]         b_prod_x_reg, b_prod_y_reg;
    logic [SW:0]           b_d2_reg;
    logic [SW-1:0]         b_dz2_reg;
    logic [5:0]            b_flags_reg;

    logic [COORD_BITS-1:0] mag_x, mag_y;
    logic signed [DW-1:0]  neg_dx, neg_dy;
    logic [15:0]           gain;

    // Stage C: frame axes and result.
    logic [AXIS_BITS-1:0]  axis_reg [4];
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [M_TDATA_W-1:0]  res_next;

    // The back moves only when the result register can take a new result.
    assign en    = !m_tvalid_reg || m_tready;
    assign q_pop = en && q_valid;

    always_comb begin
        stick_owned_next = stick_owned_reg;
        stick_owner_next = stick_owner_reg;
        stick_ox_next    = stick_ox_reg;
        stick_oy_next    = stick_oy_reg;
        look_owned_next  = look_owned_reg;
        look_owner_next  = look_owner_reg;
        look_lx_next     = look_lx_reg;
        look_ly_next     = look_ly_reg;
        flags_next       = flags_reg;
        a_kind_next      = KIND_NONE;
        a_dx_next        = '0;
        a_dy_next        = '0;
        a_flags_next     = flags_reg;
        if (q_pop) begin
            case (q_zone)
                ZONE_FIRE:  flags_next[FL_FIRE]  = 1'b1;
                ZONE_AIM:   flags_next[FL_AIM]   = 1'b1;
                ZONE_USE:   flags_next[FL_USE]   = 1'b1;
                ZONE_START: flags_next[FL_START] = 1'b1;
                ZONE_MOVE: begin
                    if (!stick_owned_reg) begin
                        // A new owner lands on its own centre, so the deflection is zero.
                        stick_owned_next     = 1'b1;
                        stick_owner_next     = q_id;
                        stick_ox_next        = q_x;
                        stick_oy_next        = q_y;
                        flags_next[FL_MOVE]  = 1'b1;
                        a_kind_next          = KIND_MOVE;
                    end else if (q_id == stick_owner_reg) begin
                        flags_next[FL_MOVE]  = 1'b1;
                        a_kind_next          = KIND_MOVE;
                        a_dx_next = $signed({1'b0, q_x}) - $signed({1'b0, stick_ox_reg});
                        a_dy_next = $signed({1'b0, q_y}) - $signed({1'b0, stick_oy_reg});
                    end
                end
                ZONE_LOOK: begin
                    if (!look_owned_reg) begin
                        look_owned_next     = 1'b1;
                        look_owner_next     = q_id;
                        look_lx_next        = q_x;
                        look_ly_next        = q_y;
                        flags_next[FL_LOOK] = 1'b1;
                    end else if (q_id == look_owner_reg) begin
                        flags_next[FL_LOOK] = 1'b1;
                        a_kind_next         = KIND_LOOK;
                        a_dx_next = $signed({1'b0, q_x}) - $signed({1'b0, look_lx_reg});
                        a_dy_next = $signed({1'b0, q_y}) - $signed({1'b0, look_ly_reg});
                        look_lx_next        = q_x;
                        look_ly_next        = q_y;
                    end
                end
                ZONE_EOF: begin
                    // Owners not seen during the frame let go.
                    a_kind_next = KIND_EOF;
                    if (!flags_reg[FL_MOVE]) begin
                        stick_owned_next = 1'b0;
                    end
                    if (!flags_reg[FL_LOOK]) begin
                        look_owned_next = 1'b0;
                    end
                    flags_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stick_owned_reg <= 1'b0;
            stick_owner_reg <= '0;
            stick_ox_reg    <= '0;
            stick_oy_reg    <= '0;
            look_owned_reg  <= 1'b0;
            look_owner_reg  <= '0;
            look_lx_reg     <= '0;
            look_ly_reg     <= '0;
            flags_reg       <= '0;
            a_kind_reg      <= KIND_NONE;
        end else begin
            stick_owned_reg <= stick_owned_next;
            stick_owner_reg <= stick_owner_next;
            stick_ox_reg    <= stick_ox_next;
            stick_oy_reg    <= stick_oy_next;
            look_owned_reg  <= look_owned_next;
            look_owner_reg  <= look_owner_next;
            look_lx_reg     <= look_lx_next;
            look_ly_reg     <= look_ly_next;
            flags_reg       <= flags_next;
            if (en) begin
                a_kind_reg <= a_kind_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_dx_reg    <= a_dx_next;
            a_dy_reg    <= a_dy_next;
            a_flags_reg <= a_flags_next;
        end
    end

    // A displacement never exceeds full scale, so its magnitude fits the coordinate width.
    assign neg_dx = -a_dx_reg;
    assign neg_dy = -a_dy_reg;
    assign mag_x  = a_dx_reg[DW-1] ? neg_dx[COORD_BITS-1:0] : a_dx_reg[COORD_BITS-1:0];
    assign mag_y  = a_dy_reg[DW-1] ? neg_dy[COORD_BITS-1:0] : a_dy_reg[COORD_BITS-1:0];
    assign gain   = (a_kind_reg == KIND_LOOK) ? look_gain : move_scale;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_kind_reg <= KIND_NONE;
        end else if (en) begin
            b_kind_reg <= a_kind_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_neg_x_reg  <= a_dx_reg[DW-1];
            b_neg_y_reg  <= a_dy_reg[DW-1];
            b_prod_x_reg <= PW'(mag_x) * PW'(gain);
            b_prod_y_reg <= PW'(mag_y) * PW'(gain);
            b_d2_reg     <= (SW + 1)'(SW'(mag_x) * SW'(mag_x))
                          + (SW + 1)'(SW'(mag_y) * SW'(mag_y));
            b_dz2_reg    <= SW'(move_deadzone) * SW'(move_deadzone);
            b_flags_reg  <= a_flags_reg;
        end
    end

    // The result carries only the axes of owners seen in the frame.
    always_comb begin
        res_next = '0;
        if (b_flags_reg[FL_MOVE]) begin
            res_next[AXIS_BITS-1:0]             = axis_reg[0];
            res_next[2*AXIS_BITS-1:AXIS_BITS]   = axis_reg[1];
        end
        if (b_flags_reg[FL_LOOK]) begin
            res_next[3*AXIS_BITS-1:2*AXIS_BITS] = axis_reg[2];
            res_next[4*AXIS_BITS-1:3*AXIS_BITS] = axis_reg[3];
        end
        res_next[4*AXIS_BITS]     = b_flags_reg[FL_FIRE];
        res_next[4*AXIS_BITS + 1] = b_flags_reg[FL_AIM];
        res_next[4*AXIS_BITS + 2] = b_flags_reg[FL_USE];
        res_next[4*AXIS_BITS + 3] = b_flags_reg[FL_START];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            axis_reg[0]  <= '0;
            axis_reg[1]  <= '0;
            axis_reg[2]  <= '0;
            axis_reg[3]  <= '0;
        end else if (en) begin
            m_tvalid_reg <= (b_kind_reg == KIND_EOF);
            case (b_kind_reg)
                KIND_MOVE: begin
                    if (b_d2_reg < {1'b0, b_dz2_reg}) begin
                        axis_reg[0] <= '0;
                        axis_reg[1] <= '0;
                    end else begin
                        axis_reg[0] <= sat_axis(b_prod_x_reg, b_neg_x_reg);
                        axis_reg[1] <= sat_axis(b_prod_y_reg, b_neg_y_reg);
                    end
                end
                KIND_LOOK: begin
                    axis_reg[2] <= sat_axis(b_prod_x_reg, b_neg_x_reg);
                    axis_reg[3] <= sat_axis(b_prod_y_reg, b_neg_y_reg);
                end
                KIND_EOF: begin
                    axis_reg[0] <= '0;
                    axis_reg[1] <= '0;
                    axis_reg[2] <= '0;
                    axis_reg[3] <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en && b_kind_reg == KIND_EOF) begin
            m_tdata_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
